@@ rtl/core/active_set_swap_remove_table_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the active set table
// Concurrent property wrappers: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ACTIVE_SET_SWAP_REMOVE_TABLE_MACROS_SVH
`define ACTIVE_SET_SWAP_REMOVE_TABLE_MACROS_SVH

// ante |-> cons, disabled while reset is asserted
`define ASRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("asrt: property failed");

// ante |=> cons, disabled while reset is asserted
`define ASRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("asrt: property failed");

`endif

@@ rtl/core/asrt_pkg.sv @@
// ----------------------------------------------------------------------------
// asrt_pkg
// Types and constants shared by the active set table modules.
// ----------------------------------------------------------------------------
package asrt_pkg;

    localparam int CAPACITY_DEF     = 256;
    localparam int ENTITY_SPACE_DEF = 1024;
    localparam int QUEUE_DEPTH      = 2;

    localparam int ID_W     = 10;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 9;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ACTIVE   = 3'd1,
        ST_INACTIVE = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_FIX
    } t_back_state;

    typedef struct packed {
        t_req              req;
        logic [ID_W-1:0]   entity;
        logic [IDX_W-1:0]  read_index;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  position;
        logic [ID_W-1:0]   entity_out;
        logic              moved_valid;
        logic [CNT_W-1:0]  active_count;
    } t_result;

endpackage

@@ rtl/core/asrt_front.sv @@
// ----------------------------------------------------------------------------
// asrt_front
// Input stage: takes requests, wraps the entity id into the id space and
// holds the decoded command until the queue takes it.
// ----------------------------------------------------------------------------
module asrt_front #(
    parameter int ENTITY_SPACE = asrt_pkg::ENTITY_SPACE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [asrt_pkg::ID_W-1:0]   i_entity_id,
    input  logic [asrt_pkg::IDX_W-1:0]  i_read_index,
    input  logic                        i_hold,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output asrt_pkg::t_cmd              o_cmd
);

    localparam longint ID_MAX = (longint'(1) << asrt_pkg::ID_W) - 1;

    // conditional subtract of space * 2^k, top down
    function automatic logic [asrt_pkg::ID_W-1:0] reduce_id(
        input logic [asrt_pkg::ID_W-1:0] id
    );
        logic [asrt_pkg::ID_W-1:0] v;
        longint                    step;
        v = id;
        for (int k = asrt_pkg::ID_W - 1; k >= 0; k--) begin
            step = longint'(ENTITY_SPACE) << k;
            if (step <= ID_MAX && longint'(v) >= step) begin
                v = v - asrt_pkg::ID_W'(step);
            end
        end
        return v;
    endfunction

    logic           r_valid, n_valid;
    asrt_pkg::t_cmd r_cmd, n_cmd;
    logic           accept;

    assign o_ready     = !i_hold && (!r_valid || i_cmd_ready);
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid            = 1'b1;
            n_cmd.req          = asrt_pkg::t_req'(i_req_type);
            n_cmd.entity       = reduce_id(i_entity_id);
            n_cmd.read_index   = i_read_index;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

@@ rtl/core/asrt_queue.sv @@
// ----------------------------------------------------------------------------
// asrt_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module asrt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  asrt_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output asrt_pkg::t_cmd o_pop_cmd
);

    localparam int DEPTH = asrt_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    asrt_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            push, pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

@@ rtl/core/asrt_back.sv @@
// ----------------------------------------------------------------------------
// asrt_back
// Execution engine: dense id array, position map, count and result register.
// Sweeps the position map inactive after reset.
// ----------------------------------------------------------------------------
module asrt_back #(
    parameter int CAPACITY     = asrt_pkg::CAPACITY_DEF,
    parameter int ENTITY_SPACE = asrt_pkg::ENTITY_SPACE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  asrt_pkg::t_cmd    i_cmd,
    output logic              o_clearing,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output asrt_pkg::t_result o_res
);

    localparam int PW = $clog2(CAPACITY);
    localparam int EW = $clog2(ENTITY_SPACE);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = PW + 1;

    asrt_pkg::t_back_state r_state, n_state;
    asrt_pkg::t_cmd        r_cmd, n_cmd;
    logic [CW-1:0]         r_count, n_count;
    logic [EW-1:0]         r_clr, n_clr;
    logic [EW-1:0]         r_fix_id, n_fix_id;
    logic [PW-1:0]         r_fix_pos, n_fix_pos;
    logic                  r_res_valid, n_res_valid;
    asrt_pkg::t_result     r_res, n_res;

    logic [EW-1:0]         r_dense [CAPACITY];
    logic [MW-1:0]         r_map   [ENTITY_SPACE];
    logic [EW-1:0]         r_dense_q;
    logic [MW-1:0]         r_map_q;

    logic                  dense_we, dense_re;
    logic [PW-1:0]         dense_waddr, dense_raddr;
    logic [EW-1:0]         dense_wdata;
    logic                  map_we, map_re;
    logic [EW-1:0]         map_waddr, map_raddr;
    logic [MW-1:0]         map_wdata;

    logic                  m_valid;
    logic [PW-1:0]         m_pos;
    logic [CW-1:0]         last;
    logic [EW-1:0]         ent;

    assign m_valid     = r_map_q[MW-1];
    assign m_pos       = r_map_q[PW-1:0];
    assign last        = r_count - CW'(1);
    assign ent         = EW'(r_cmd.entity);
    assign o_cmd_ready = (r_state == asrt_pkg::S_IDLE);
    assign o_clearing  = (r_state == asrt_pkg::S_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_clr       = r_clr;
        n_fix_id    = r_fix_id;
        n_fix_pos   = r_fix_pos;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        dense_re    = 1'b0;
        dense_raddr = '0;
        map_we      = 1'b0;
        map_waddr   = '0;
        map_wdata   = '0;
        map_re      = 1'b0;
        map_raddr   = '0;

        case (r_state)
            asrt_pkg::S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                if (r_clr == EW'(ENTITY_SPACE - 1)) begin
                    n_state = asrt_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + EW'(1);
                end
            end
            asrt_pkg::S_IDLE: begin
                map_re    = 1'b1;
                map_raddr = EW'(i_cmd.entity);
                dense_re  = 1'b1;
                if (i_cmd.req == asrt_pkg::REQ_READ) begin
                    dense_raddr = PW'(i_cmd.read_index);
                end else begin
                    dense_raddr = PW'(last);
                end
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_state = asrt_pkg::S_EVAL;
                end
            end
            asrt_pkg::S_EVAL: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res_valid        = 1'b1;
                    n_state            = asrt_pkg::S_IDLE;
                    n_res.status       = asrt_pkg::ST_OK;
                    n_res.position     = '0;
                    n_res.entity_out   = '0;
                    n_res.moved_valid  = 1'b0;
                    n_res.active_count = asrt_pkg::CNT_W'(r_count);
                    case (r_cmd.req)
                        asrt_pkg::REQ_ADD: begin
                            if (m_valid) begin
                                n_res.status   = asrt_pkg::ST_ACTIVE;
                                n_res.position = asrt_pkg::IDX_W'(m_pos);
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_res.status = asrt_pkg::ST_FULL;
                            end else begin
                                dense_we           = 1'b1;
                                dense_waddr        = PW'(r_count);
                                dense_wdata        = ent;
                                map_we             = 1'b1;
                                map_waddr          = ent;
                                map_wdata          = {1'b1, PW'(r_count)};
                                n_count            = r_count + CW'(1);
                                n_res.position     = asrt_pkg::IDX_W'(r_count);
                                n_res.active_count = asrt_pkg::CNT_W'(n_count);
                            end
                        end
                        asrt_pkg::REQ_REMOVE: begin
                            if (!m_valid || r_count == '0) begin
                                n_res.status = asrt_pkg::ST_INACTIVE;
                            end else begin
                                map_we             = 1'b1;
                                map_waddr          = ent;
                                map_wdata          = '0;
                                n_count            = last;
                                n_res.position     = asrt_pkg::IDX_W'(m_pos);
                                n_res.active_count = asrt_pkg::CNT_W'(last);
                                if (CW'(m_pos) < last) begin
                                    dense_we          = 1'b1;
                                    dense_waddr       = m_pos;
                                    dense_wdata       = r_dense_q;
                                    n_res.entity_out  = asrt_pkg::ID_W'(r_dense_q);
                                    n_res.moved_valid = 1'b1;
                                    n_fix_id          = r_dense_q;
                                    n_fix_pos         = m_pos;
                                    n_state           = asrt_pkg::S_FIX;
                                end
                            end
                        end
                        asrt_pkg::REQ_READ: begin
                            n_res.position = r_cmd.read_index;
                            if (32'(r_cmd.read_index) >= 32'(r_count)
                                || 32'(r_cmd.read_index) >= CAPACITY) begin
                                n_res.status = asrt_pkg::ST_RANGE;
                            end else begin
                                n_res.entity_out = asrt_pkg::ID_W'(r_dense_q);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            asrt_pkg::S_FIX: begin
                map_we    = 1'b1;
                map_waddr = r_fix_id;
                map_wdata = {1'b1, r_fix_pos};
                n_state   = asrt_pkg::S_IDLE;
            end
            default: begin
                n_state = asrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asrt_pkg::S_CLEAR;
            r_count     <= '0;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
        r_cmd     <= n_cmd;
        r_fix_id  <= n_fix_id;
        r_fix_pos <= n_fix_pos;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (dense_we) begin
            r_dense[dense_waddr] <= dense_wdata;
        end
        if (dense_re) begin
            r_dense_q <= r_dense[dense_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            r_map_q <= r_map[map_raddr];
        end
    end

endmodule

@@ rtl/core/active_set_swap_remove_table.sv @@
// ----------------------------------------------------------------------------
// active_set_swap_remove_table: packed active id set with swap-remove
// Path: front register, queue, back-end memory read, result register. The back
// end takes a request only when idle: memory read, then evaluate and write, plus
// a fix step when a remove moves the last id (one position map write port).
// Reset: count cleared, position map swept inactive entry by entry.
// ----------------------------------------------------------------------------
`include "active_set_swap_remove_table_macros.svh"

module active_set_swap_remove_table #(
    parameter int CAPACITY     = asrt_pkg::CAPACITY_DEF,
    parameter int ENTITY_SPACE = asrt_pkg::ENTITY_SPACE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [asrt_pkg::ID_W-1:0]      i_entity_id,
    input  logic [asrt_pkg::IDX_W-1:0]     i_read_index,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [asrt_pkg::STATUS_W-1:0]  o_status,
    output logic [asrt_pkg::IDX_W-1:0]     o_position,
    output logic [asrt_pkg::ID_W-1:0]      o_entity_out,
    output logic                           o_moved_valid,
    output logic [asrt_pkg::CNT_W-1:0]     o_active_count
);

    logic              clearing;
    logic              f_valid, q_push_ready;
    asrt_pkg::t_cmd    f_cmd;
    logic              q_valid, b_ready;
    asrt_pkg::t_cmd    q_cmd;
    asrt_pkg::t_result res;

    asrt_front #(
        .ENTITY_SPACE (ENTITY_SPACE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_entity_id  (i_entity_id),
        .i_read_index (i_read_index),
        .i_hold       (clearing),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (q_push_ready),
        .o_cmd        (f_cmd)
    );

    asrt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (q_push_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (b_ready),
        .o_pop_cmd    (q_cmd)
    );

    asrt_back #(
        .CAPACITY     (CAPACITY),
        .ENTITY_SPACE (ENTITY_SPACE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (b_ready),
        .i_cmd       (q_cmd),
        .o_clearing  (clearing),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (res)
    );

    assign o_status       = res.status;
    assign o_position     = res.position;
    assign o_entity_out   = res.entity_out;
    assign o_moved_valid  = res.moved_valid;
    assign o_active_count = res.active_count;

    `ASRT_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, clearing, !(i_valid && o_ready))
    `ASRT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, 32'(o_active_count) <= CAPACITY)
    `ASRT_ASSERT_NOW(a_moved_ok, i_clk, i_rst_n, o_valid && o_moved_valid, o_status == asrt_pkg::ST_OK)
    `ASRT_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_status != asrt_pkg::ST_OK, o_entity_out == '0 && !o_moved_valid)

endmodule
